### rtl/gmd_pkg.sv
// Package: shared types and constants for the grid maze path search block.
`default_nettype none
package gmd_pkg;
   localparam int unsigned NCELLS = 64;
   localparam int unsigned MAX_SIDE = 8;

   typedef enum logic [1:0] {
      OP_DEFAULT = 2'd0,
      OP_OPEN    = 2'd1,
      OP_SOLVE   = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHECK,
      ST_PROBE,
      ST_DECIDE,
      ST_POP,
      ST_EMIT_RD,
      ST_EMIT,
      ST_FAIL
   } state_type;

   typedef struct packed {
      logic grid_default;
      logic grid_open;
      logic clear_step;
      logic start;
      logic probe;
      logic push;
      logic advance;
      logic pop;
      logic emit_start;
      logic emit_read;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic at_goal;
      logic next_done;
      logic cand_ok;
      logic empty;
      logic emit_last;
   } sts_type;
endpackage
`default_nettype wire

### rtl/gmd_if.sv
// Interface: valid/ready channel carrying one payload.
`default_nettype none
interface gmd_if #(parameter int unsigned W = 8) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/grid_maze_dfs_path.sv
// Top level: depth-first path search through a square maze grid.
//  channel | dir | payload
//  req     | in  | func[1:0] row[2:0] col[2:0]
//  rsp     | out | cell_res[5:0] found last
//  csr     | in  | side[3:0], write enable only
// After acceptance a solve clears, runs each neighbour probe through check,
// probe and decide, each pop through check and pop, ends with a final check,
// then reads and emits each path cell or gives the no-path result; one
// neighbour tried at a time sets the pace. Reset is synchronous and restores
// side 8 and the default grid. The output stall holds the current path cell
// until taken; no new transaction is taken during a solve.
`default_nettype none
module grid_maze_dfs_path (
   input  wire logic   clock,
   input  wire logic   reset,
   gmd_if.sink         req,
   gmd_if.source       rsp,
   input  wire logic       csr_we,
   input  wire logic [3:0] csr_wdata
);
   import gmd_pkg::*;
   logic [3:0] side_ff;
   logic [2:0] side_m1;
   cmd_type    cmd;
   sts_type    sts;
   logic       fail;
   logic [5:0] path_cell;

   always_ff @(posedge clock) begin
      if (reset) side_ff <= 4'd8;
      else if (csr_we) side_ff <= csr_wdata;
   end

   // out-of-range side clamps to 2..MAX_SIDE
   always_comb begin
      if (side_ff < 4'd2) side_m1 = 3'd1;
      else if (side_ff > 4'(MAX_SIDE)) side_m1 = 3'(MAX_SIDE - 1);
      else side_m1 = 3'(side_ff - 4'd1);
   end

   gmd_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_func(req.data[7:6]), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_fail(fail),
      .cmd, .sts
   );

   gmd_dp u_dp (
      .clock, .reset, .side_m1,
      .req_row(req.data[5:3]), .req_col(req.data[2:0]),
      .cmd, .sts, .cell_out(path_cell)
   );

   // payload {cell_res, found, last}
   assign rsp.data = fail ? 8'b0000_0001 : {path_cell, 1'b1, sts.emit_last};
endmodule
`default_nettype wire

### rtl/gmd_ctrl.sv
// Controller: sequences grid updates, the search and the path output.
`default_nettype none
module gmd_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_func,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic                 rsp_fail,
   output gmd_pkg::cmd_type     cmd,
   input  wire gmd_pkg::sts_type sts
);
   import gmd_pkg::*;
   state_type state_ff, state_in;
   logic acc;
   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (acc && req_func == OP_SOLVE) state_in = ST_CLEAR;
         ST_CLEAR:   if (sts.clear_done) state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.empty) state_in = ST_FAIL;
            else if (sts.at_goal) state_in = ST_EMIT_RD;
            else if (sts.next_done) state_in = ST_POP;
            else state_in = ST_PROBE;
         end
         ST_PROBE:   state_in = ST_DECIDE;
         ST_DECIDE:  state_in = ST_CHECK;
         ST_POP:     state_in = ST_CHECK;
         ST_EMIT_RD: state_in = ST_EMIT;
         ST_EMIT:    if (rsp_ready) state_in = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
         ST_FAIL:    if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_fail = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.grid_default = acc && req_func == OP_DEFAULT;
            cmd.grid_open = acc && req_func == OP_OPEN;
            cmd.start = acc && req_func == OP_SOLVE;
         end
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_CHECK: begin
            cmd.emit_start = !sts.empty && sts.at_goal;
            cmd.probe = !sts.empty && !sts.at_goal && !sts.next_done;
         end
         ST_DECIDE: begin
            cmd.push = sts.cand_ok;
            cmd.advance = 1'b1;
         end
         ST_POP: cmd.pop = 1'b1;
         ST_EMIT_RD: cmd.emit_read = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_next = rsp_ready;
         end
         ST_FAIL: begin
            rsp_valid = 1'b1;
            rsp_fail = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

### rtl/gmd_dp.sv
// Datapath: grid, visited marks, search stack and path cell numbering.
`default_nettype none
module gmd_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [2:0]       side_m1,
   input  wire logic [2:0]       req_row,
   input  wire logic [2:0]       req_col,
   input  wire gmd_pkg::cmd_type cmd,
   output gmd_pkg::sts_type      sts,
   output logic [5:0]            cell_out
);
   import gmd_pkg::*;
   logic [NCELLS-1:0] grid_ff, grid_in;
   logic [NCELLS-1:0] vis_ff, vis_in;
   // stack memory: {row, col}; next index of top frame kept in register
   logic [5:0] stk_mem [NCELLS];
   logic [3:0] nxt_mem [NCELLS];
   logic [6:0] depth_ff;
   logic [5:0] top_ff;   // row,col of top frame
   logic [3:0] next_ff;  // neighbour index of top frame
   logic [5:0] cand_ff;
   logic       cand_ok_ff;
   logic [5:0] emit_ff, emit_in;  // emit read pointer
   logic [5:0] rd_addr;
   logic [3:0] nr, nc;
   logic       in_grid;
   logic [5:0] cidx;

   // cell number row*side+col of a stored frame, top frame held in register
   function automatic logic [5:0] stk_rd(input logic [5:0] m, input logic [5:0] t,
                                         input logic is_top);
      logic [5:0] rc;
      logic [6:0] v;
      rc = is_top ? t : m;
      v = {4'b0000, rc[5:3]} * ({4'b0000, side_m1} + 7'd1) + {4'b0000, rc[2:0]};
      return v[5:0];
   endfunction

   // candidate neighbour from top frame
   always_comb begin
      logic [1:0] dr, dc;
      dr = (next_ff >= 4'd6) ? 2'd2 : (next_ff >= 4'd3) ? 2'd1 : 2'd0;
      dc = 2'(next_ff - {dr, 2'b00} + {2'b00, dr});
      nr = {1'b0, top_ff[5:3]} + {2'b00, dr} - 4'd1;
      nc = {1'b0, top_ff[2:0]} + {2'b00, dc} - 4'd1;
      in_grid = (next_ff != 4'd4) && !nr[3] && !nc[3] &&
                (nr[2:0] <= side_m1) && (nc[2:0] <= side_m1);
      cidx = {nr[2:0], nc[2:0]};
   end

   always_comb begin
      grid_in = grid_ff;
      if (cmd.grid_default) begin
         grid_in = '0;
         grid_in[0] = 1'b1;
         grid_in[{side_m1, side_m1}] = 1'b1;
      end else if (cmd.grid_open && req_row <= side_m1 && req_col <= side_m1) begin
         grid_in[{req_row, req_col}] = 1'b1;
      end
      vis_in = vis_ff;
      if (cmd.start) vis_in = '0;
      else if (cmd.clear_step) vis_in[0] = 1'b1;
      else if (cmd.push) vis_in[cand_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= NCELLS'(1) | (NCELLS'(1) << (NCELLS - 1));
         vis_ff <= '0;
         depth_ff <= '0;
      end else begin
         grid_ff <= grid_in;
         vis_ff <= vis_in;
         if (cmd.clear_step) depth_ff <= 7'd1;
         else if (cmd.push) depth_ff <= depth_ff + 7'd1;
         else if (cmd.pop) depth_ff <= depth_ff - 7'd1;
      end
   end

   // frame below the top, restored into the top registers on a pop
   assign rd_addr = 6'(depth_ff - 7'd2);

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         top_ff <= '0;
         next_ff <= '0;
      end else if (cmd.probe) begin
         cand_ff <= cidx;
         cand_ok_ff <= in_grid && grid_ff[cidx] && !vis_ff[cidx];
      end else if (cmd.push) begin
         stk_mem[depth_ff[5:0] - 6'd1] <= top_ff;
         nxt_mem[depth_ff[5:0] - 6'd1] <= next_ff + 4'd1;
         top_ff <= cand_ff;
         next_ff <= '0;
      end else if (cmd.advance) begin
         next_ff <= next_ff + 4'd1;
      end else if (cmd.pop) begin
         top_ff <= stk_mem[rd_addr];
         next_ff <= nxt_mem[rd_addr];
      end
      if (cmd.emit_read) cell_out <= stk_rd(stk_mem[emit_ff], top_ff,
                                            emit_ff == 6'(depth_ff - 7'd1));
   end

   always_comb begin
      emit_in = emit_ff;
      if (cmd.emit_start) emit_in = '0;
      else if (cmd.emit_next) emit_in = emit_ff + 6'd1;
   end
   always_ff @(posedge clock) emit_ff <= emit_in;

   assign sts.clear_done = 1'b1;
   assign sts.at_goal = top_ff == {side_m1, side_m1};
   assign sts.next_done = next_ff >= 4'd9;
   assign sts.cand_ok = cand_ok_ff;
   assign sts.empty = depth_ff == 7'd0;
   assign sts.emit_last = emit_ff == 6'(depth_ff - 7'd1);
endmodule
`default_nettype wire
